// ===== sv/tccur_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console cursor engine.
// No dependencies; imported by every module of the block.
package tccur_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int COL_LIM  = (MAX_COLS < 128) ? MAX_COLS : 128;
    localparam int ROW_LIM  = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int TAB_STOP = 4;

    // command codes
    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_CURSOR    = 3'd1;
    localparam logic [2:0] CMD_GLYPH     = 3'd2;
    localparam logic [2:0] CMD_SCROLL    = 3'd3;
    localparam logic [2:0] CMD_CLEAR_ROW = 3'd4;

    // character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // configuration register indexes
    localparam logic [1:0] REG_COLUMNS        = 2'd0;
    localparam logic [1:0] REG_ROWS           = 2'd1;
    localparam logic [1:0] REG_CURSOR_VISIBLE = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic [7:0]  char_code;
        logic [23:0] text_color;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  cell_col;
        logic [5:0]  cell_row;
        logic [7:0]  glyph;
        logic [23:0] glyph_color;
        logic        last;
    } t_out_word;

    // datapath operation for the current cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_GLYPH,
        OP_SCROLL,
        OP_CLRROW,
        OP_SCUR,
        OP_PCUR,
        OP_ERASE,
        OP_FINAL
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_ctl;

    typedef struct packed {
        logic out_free;
        logic is_nl;
        logic is_tab;
        logic is_bs;
        logic at_origin;
        logic at_last_col;
        logic at_last_row;
        logic tab_more;
    } t_sts;

endpackage

// ===== sv/text_console_cursor_engine_core.sv =====
`timescale 1ns / 1ps
// Text console cursor engine: one input word gives a run of 2 to 25 command words.
// The first command word (a cell clear) is registered from S_CLEAR, which follows the load.
// Command words leave the single output register at one per cycle while the output is not
// stalled; a word holds the sequencer from its load until its final command is registered.
// Reset (synchronous, active low): cursor to 0,0; columns 80, rows 25, cursor shown.
module text_console_cursor_engine_core import tccur_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    tccur_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    tccur_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // a word is only loaded from idle, and its run opens with a cell clear
    a_load_then_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |=> (ctl.op == OP_CLEAR))
        else $error("run did not start with a cell clear");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |-> (ctl.op == OP_NONE) && !o_in_stall)
        else $error("word loaded while a run was active");

    a_glyph_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.command != CMD_GLYPH)) |->
            (o_out_word.glyph == 8'd0) && (o_out_word.glyph_color == 24'd0))
        else $error("glyph fields set on a non-glyph command");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.op == OP_FINAL) && sts.out_free |=> !o_in_stall)
        else $error("sequencer busy after final command");

endmodule

// ===== sv/tccur_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the cursor engine: steps through the command run of a word.
// Depends on tccur_pkg; drives tccur_datapath through t_ctl.
module tccur_ctrl import tccur_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_in_stall
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_GLYPH  = 9'b000000100,
        S_SCROLL = 9'b000001000,
        S_CLRROW = 9'b000010000,
        S_SCUR   = 9'b000100000,
        S_PCUR   = 9'b001000000,
        S_ERASE  = 9'b010000000,
        S_FINAL  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl.load = 1'b0;
        o_ctl.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_ctl.op = OP_CLEAR;
                if (i_sts.out_free) begin
                    if (i_sts.is_nl) begin
                        n_state = i_sts.at_last_row ? S_SCROLL : S_FINAL;
                    end else if (i_sts.is_bs) begin
                        n_state = i_sts.at_origin ? S_FINAL : S_ERASE;
                    end else begin
                        n_state = S_GLYPH;
                    end
                end
            end
            S_GLYPH: begin
                o_ctl.op = OP_GLYPH;
                if (i_sts.out_free) begin
                    n_state = (i_sts.at_last_col && i_sts.at_last_row) ? S_SCROLL : S_PCUR;
                end
            end
            S_SCROLL: begin
                o_ctl.op = OP_SCROLL;
                if (i_sts.out_free) n_state = S_CLRROW;
            end
            S_CLRROW: begin
                o_ctl.op = OP_CLRROW;
                if (i_sts.out_free) n_state = S_SCUR;
            end
            S_SCUR: begin
                o_ctl.op = OP_SCUR;
                if (i_sts.out_free) n_state = i_sts.is_nl ? S_FINAL : S_PCUR;
            end
            S_PCUR: begin
                o_ctl.op = OP_PCUR;
                if (i_sts.out_free) begin
                    n_state = (i_sts.is_tab && i_sts.tab_more) ? S_CLEAR : S_FINAL;
                end
            end
            S_ERASE: begin
                o_ctl.op = OP_ERASE;
                if (i_sts.out_free) n_state = S_FINAL;
            end
            S_FINAL: begin
                o_ctl.op = OP_FINAL;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== sv/tccur_datapath.sv =====
`timescale 1ns / 1ps
// Cursor position, screen configuration and the output word register.
// Depends on tccur_pkg; sequenced by tccur_ctrl.
module tccur_datapath import tccur_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    output t_sts                  o_sts,
    input  t_in_word              i_in_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_word             o_out_word
);

    logic [7:0]  r_columns;
    logic [6:0]  r_rows;
    logic        r_cursor_vis;
    logic [6:0]  r_col, n_col;
    logic [5:0]  r_row, n_row;
    logic [2:0]  r_tab_cnt, n_tab_cnt;
    logic [7:0]  r_char;
    logic [23:0] r_color;
    logic        r_nl, r_tab, r_bs;
    logic        r_out_valid;
    t_out_word   r_out, n_out;

    logic [7:0] ncols;
    logic [6:0] nrows;
    logic [6:0] col_max, sat_col;
    logic [5:0] row_max, sat_row;
    logic       out_free, emit;
    logic [2:0] cursor_code;

    // clamp the screen size into the supported range
    always_comb begin
        ncols = r_columns;
        if (r_columns == 8'd0) ncols = 8'd1;
        else if (r_columns > 8'(COL_LIM)) ncols = 8'(COL_LIM);
        nrows = r_rows;
        if (r_rows == 7'd0) nrows = 7'd1;
        else if (r_rows > 7'(ROW_LIM)) nrows = 7'(ROW_LIM);
    end

    assign col_max = 7'(ncols - 8'd1);
    assign row_max = 6'(nrows - 7'd1);
    assign sat_col = (r_col > col_max) ? col_max : r_col;
    assign sat_row = (r_row > row_max) ? row_max : r_row;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit        = out_free && (i_ctl.op != OP_NONE);
    assign cursor_code = r_cursor_vis ? CMD_CURSOR : CMD_CLEAR;

    assign o_sts.out_free    = out_free;
    assign o_sts.is_nl       = r_nl;
    assign o_sts.is_tab      = r_tab;
    assign o_sts.is_bs       = r_bs;
    assign o_sts.at_origin   = (r_col == 7'd0) && (r_row == 6'd0);
    assign o_sts.at_last_col = (r_col == col_max);
    assign o_sts.at_last_row = (r_row == row_max);
    assign o_sts.tab_more    = (r_tab_cnt > 3'd1);

    // next cursor and the word to load
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_tab_cnt = r_tab_cnt;
        n_out     = '0;
        n_out.cell_col = r_col;
        n_out.cell_row = r_row;
        unique case (i_ctl.op)
            OP_CLEAR: begin
                n_out.command = CMD_CLEAR;
                if (r_nl) begin
                    // last row: the row stays, the scroll run follows
                    n_col = 7'd0;
                    if (r_row != row_max) n_row = r_row + 6'd1;
                end else if (r_bs) begin
                    if (r_col != 7'd0) begin
                        n_col = r_col - 7'd1;
                    end else if (r_row != 6'd0) begin
                        n_col = col_max;
                        n_row = r_row - 6'd1;
                    end
                end
            end
            OP_GLYPH: begin
                n_out.command     = CMD_GLYPH;
                n_out.glyph       = r_tab ? CH_SPACE : r_char;
                n_out.glyph_color = r_color;
                if (r_col == col_max) begin
                    n_col = 7'd0;
                    if (r_row != row_max) n_row = r_row + 6'd1;
                end else begin
                    n_col = r_col + 7'd1;
                end
            end
            OP_SCROLL: begin
                n_out.command  = CMD_SCROLL;
                n_out.cell_col = 7'd0;
                n_out.cell_row = 6'd0;
            end
            OP_CLRROW: begin
                n_out.command  = CMD_CLEAR_ROW;
                n_out.cell_col = 7'd0;
            end
            OP_SCUR: begin
                n_out.command = cursor_code;
            end
            OP_PCUR: begin
                n_out.command = cursor_code;
                if (r_tab) n_tab_cnt = r_tab_cnt - 3'd1;
            end
            OP_ERASE: begin
                n_out.command = CMD_CLEAR;
            end
            OP_FINAL: begin
                n_out.command = cursor_code;
                n_out.last    = 1'b1;
            end
            default: n_out.command = CMD_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns    <= 8'd80;
            r_rows       <= 7'd25;
            r_cursor_vis <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COLUMNS:        r_columns    <= i_cfg_data;
                REG_ROWS:           r_rows       <= i_cfg_data[6:0];
                REG_CURSOR_VISIBLE: r_cursor_vis <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                // screen may have shrunk under the cursor
                r_col <= sat_col;
                r_row <= sat_row;
            end else if (emit) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (emit) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_char    <= i_in_word.char_code;
            r_color   <= i_in_word.text_color;
            r_nl      <= (i_in_word.char_code == CH_NEWLINE);
            r_tab     <= (i_in_word.char_code == CH_TAB);
            r_bs      <= (i_in_word.char_code == CH_BACKSPACE);
            r_tab_cnt <= 3'(TAB_STOP) - 3'(sat_col % TAB_STOP);
        end else if (emit) begin
            r_tab_cnt <= n_tab_cnt;
        end
        if (emit) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== test/text_console_cursor_engine_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for text_console_cursor_engine_core: directed edits, then random text on many
// screen sizes, with every command word checked against a predicted console. Needs tccur_pkg.
module text_console_cursor_engine_core_tb;
    import tccur_pkg::*;

    localparam int         CLK_HALF    = 6;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         MAX_RUN     = 25;
    localparam int         TAIL_CYCLES = 12;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_word = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;

    text_console_cursor_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // predicted console state and registers
    logic [7:0] reg_columns = 8'd80;
    logic [6:0] reg_rows    = 7'd25;
    logic       reg_visible = 1'b1;
    int         cur_col     = 0;
    int         cur_row     = 0;

    t_out_word  char_run[$];    // commands of the character being predicted
    t_out_word  cmd_q[$];       // commands still owed by the block

    logic       idle_on = 1'b1;
    int         mismatches = 0;
    int         chars_sent = 0;
    int         cmds_checked = 0;
    int         settings_used = 0;
    int         cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding", cycles, cmd_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 6);
    end

    function automatic void push_cmd(logic [2:0] cmd, int col, int row, logic [7:0] g,
                                     logic [23:0] colr);
        t_out_word w;
        if (char_run.size() >= MAX_RUN) return;
        w.command     = cmd;
        w.cell_col    = col[6:0];
        w.cell_row    = row[5:0];
        w.glyph       = g;
        w.glyph_color = colr;
        w.last        = 1'b0;
        char_run.push_back(w);
    endfunction

    function automatic void cursor_cmd();
        push_cmd(reg_visible ? CMD_CURSOR : CMD_CLEAR, cur_col, cur_row, '0, '0);
    endfunction

    function automatic void scroll_check(int nrows);
        if (cur_row < nrows) return;
        push_cmd(CMD_SCROLL, 0, 0, '0, '0);
        push_cmd(CMD_CLEAR_ROW, 0, cur_row - 1, '0, '0);
        cur_row--;
        cur_col = 0;
        cursor_cmd();
    endfunction

    function automatic void print_glyph(logic [7:0] ch, logic [23:0] colr, int ncols, int nrows);
        push_cmd(CMD_CLEAR, cur_col, cur_row, '0, '0);
        push_cmd(CMD_GLYPH, cur_col, cur_row, ch, colr);
        cur_col++;
        if (cur_col >= ncols) begin
            cur_row++;
            cur_col = 0;
            scroll_check(nrows);
        end
        cursor_cmd();
    endfunction

    function automatic void predict_char(logic [7:0] ch, logic [23:0] colr);
        int        ncols;
        int        nrows;
        int        pad;
        t_out_word w;
        ncols = (reg_columns == 0) ? 1 : ((reg_columns > COL_LIM) ? COL_LIM : reg_columns);
        nrows = (reg_rows == 0) ? 1 : ((reg_rows > ROW_LIM) ? ROW_LIM : reg_rows);
        char_run.delete();
        // screen may have shrunk under the cursor
        if (cur_col > ncols - 1) cur_col = ncols - 1;
        if (cur_row > nrows - 1) cur_row = nrows - 1;
        if (ch == CH_NEWLINE) begin
            push_cmd(CMD_CLEAR, cur_col, cur_row, '0, '0);
            cur_row++;
            cur_col = 0;
            scroll_check(nrows);
        end else if (ch == CH_TAB) begin
            pad = TAB_STOP - (cur_col % TAB_STOP);
            repeat (pad) print_glyph(CH_SPACE, colr, ncols, nrows);
        end else if (ch == CH_BACKSPACE) begin
            push_cmd(CMD_CLEAR, cur_col, cur_row, '0, '0);
            if (cur_col == 0) begin
                if (cur_row != 0) begin
                    cur_row--;
                    cur_col = ncols - 1;
                    push_cmd(CMD_CLEAR, cur_col, cur_row, '0, '0);
                end
            end else begin
                cur_col--;
                push_cmd(CMD_CLEAR, cur_col, cur_row, '0, '0);
            end
        end else begin
            print_glyph(ch, colr, ncols, nrows);
        end
        cursor_cmd();
        w = char_run[char_run.size() - 1];
        w.last = 1'b1;
        char_run[char_run.size() - 1] = w;
        foreach (char_run[i]) cmd_q.push_back(char_run[i]);
    endfunction

    task automatic compare_field(input string name, input logic [23:0] want,
                                 input logic [23:0] got, inout logic bad);
        if (want !== got) begin
            bad = 1'b1;
            if (mismatches < 10)
                $display("%0t: %s expected 0x%0h got 0x%0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_commands
        t_out_word want;
        logic      bad;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (cmd_q.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected command word %p", $realtime, o_out_word);
                mismatches++;
            end else begin
                want = cmd_q.pop_front();
                bad  = 1'b0;
                compare_field("command", want.command, o_out_word.command, bad);
                compare_field("cell_col", want.cell_col, o_out_word.cell_col, bad);
                compare_field("cell_row", want.cell_row, o_out_word.cell_row, bad);
                compare_field("glyph", want.glyph, o_out_word.glyph, bad);
                compare_field("glyph_color", want.glyph_color, o_out_word.glyph_color, bad);
                compare_field("last", want.last, o_out_word.last, bad);
                if (bad) mismatches++;
                cmds_checked++;
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic [23:0] colr);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{char_code: ch, text_color: colr};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_char(ch, colr);
        chars_sent++;
    endtask

    // stop sending and let every owed command come out
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_COLUMNS:        reg_columns = val;
            REG_ROWS:           reg_rows = val[6:0];
            REG_CURSOR_VISIBLE: reg_visible = val[0];
            default: ;
        endcase
    endtask

    task automatic set_screen(input logic [7:0] cols, input logic [7:0] nrows,
                              input logic vis);
        drain();
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, nrows);
        write_reg(REG_CURSOR_VISIBLE, {7'd0, vis});
        settings_used++;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) return CH_NEWLINE;
        if (r < 26) return CH_TAB;
        if (r < 40) return CH_BACKSPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [23:0] pick_colour();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'h000000;
        if (r == 1) return 24'hFFFFFF;
        return 24'($urandom());
    endfunction

    // 4x2 screen: wraps both ways, backspace at origin, tab padding, scrolls
    task automatic test_basic_edits();
        set_screen(8'd4, 8'd2, 1'b1);
        send_char(CH_BACKSPACE, 24'h123456);
        send_char(8'h41, 24'hFFFFFF);
        send_char(8'h00, 24'h000000);
        send_char(8'hFF, 24'hA5A5A5);
        send_char(8'h42, 24'h5A5A5A);
        send_char(CH_BACKSPACE, 24'h000001);
        send_char(CH_BACKSPACE, 24'h800000);
        send_char(CH_TAB, 24'h00FF00);
        send_char(CH_TAB, 24'h0000FF);
        send_char(CH_NEWLINE, 24'hFFFFFF);
    endtask

    task automatic test_hidden_cursor();
        drain();
        write_reg(REG_CURSOR_VISIBLE, 8'd0);
        settings_used++;
        send_char(8'h43, 24'h0F0F0F);
        send_char(CH_NEWLINE, 24'hF0F0F0);
    endtask

    // single cell: a tab gives the longest run of commands
    task automatic test_one_cell_screen();
        set_screen(8'd1, 8'd1, 1'b1);
        send_char(CH_TAB, 24'hC0FFEE);
        send_char(8'h5A, 24'h7FFFFF);
        send_char(CH_NEWLINE, 24'h000000);
    endtask

    // park the cursor at col 6 row 3, then shrink the screen under it
    task automatic test_shrunk_screen();
        set_screen(8'd8, 8'd4, 1'b1);
        repeat (3) send_char(CH_NEWLINE, 24'h000000);
        send_char(CH_TAB, 24'h111111);
        send_char(8'h78, 24'h222222);
        send_char(8'h79, 24'h333333);
        set_screen(8'd4, 8'd2, 1'b1);
        send_char(8'h51, 24'h444444);
        send_char(CH_BACKSPACE, 24'h555555);
    endtask

    task automatic test_random_screens();
        logic [7:0] cols;
        logic [7:0] nrows;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin cols = 8'd0;   nrows = 8'd0;   end
                1: begin cols = 8'd128; nrows = 8'd64;  end
                2: begin cols = 8'd255; nrows = 8'd127; end
                3: begin cols = 8'd80;  nrows = 8'd255; end
                4: begin cols = 8'd2;   nrows = 8'd1;   end
                default: begin
                    cols  = 8'($urandom_range(1, 12));
                    nrows = 8'($urandom_range(1, 6));
                end
            endcase
            set_screen(cols, nrows, 1'($urandom_range(0, 1)));
            if (ph == 6) write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
            idle_on = (ph != 3);
            for (int k = 0; k < 25; k++) begin
                if (ph == 5 && k == 12) drain();
                send_char(pick_char(), pick_colour());
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_edits();
        test_hidden_cursor();
        test_one_cell_screen();
        test_shrunk_screen();
        test_random_screens();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d characters over %0d screen settings; %0d command words checked.",
                 chars_sent, settings_used, cmds_checked);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && cmd_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
